/* sv/srde_pkg.sv */
// shared constants, register indexes and symbol lookup for the radix digit emitter
`default_nettype none

package srde_pkg;

    localparam int VALUE_W     = 32;
    localparam int SYM_W       = 8;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = DIGIT_W + 1;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_RADIX   = 16;
    localparam int MAX_DIGITS  = 32;
    localparam int CNT_W       = 6;
    localparam int SLICE_W     = 8;
    localparam int SLICES      = VALUE_W / SLICE_W;
    localparam int SLICE_CNT_W = 2;
    localparam int TBL_W       = MAX_RADIX * SYM_W;

    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] BASE_LENGTH_RST  = 5'd10;
    localparam logic [CFG_W-1:0]   SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]   SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

    function automatic logic [SYM_W-1:0] symbol_at(
        input logic [TBL_W-1:0]   tbl,
        input logic [DIGIT_W-1:0] k
    );
        return tbl[k*SYM_W +: SYM_W];
    endfunction

endpackage

`default_nettype wire

/* sv/srde_div_slice.sv */
// divide slice: eight restoring steps of one 8-bit slice of the value by the radix
`default_nettype none

module srde_div_slice import srde_pkg::*; (
    input  wire logic [DIGIT_W-1:0] rem_in,
    input  wire logic [SLICE_W-1:0] chunk,
    input  wire logic [RADIX_W-1:0] radix,
    output logic      [DIGIT_W-1:0] rem_out,
    output logic      [SLICE_W-1:0] quot
);

    always_comb begin
        logic [DIGIT_W-1:0] r;
        logic [RADIX_W-1:0] t;
        r    = rem_in;
        quot = '0;
        for (int b = 0; b < SLICE_W; b++) begin
            t = {r, chunk[SLICE_W-1-b]};
            if (t >= radix) begin
                quot[SLICE_W-1-b] = 1'b1;
                r = DIGIT_W'(t - radix);
            end else begin
                r = t[DIGIT_W-1:0];
            end
        end
        rem_out = r;
    end

endmodule

`default_nettype wire

/* sv/signed_radix_digit_emitter.sv */
// top level: alphabet check, digit extraction and symbol output sequencer
// each value runs the alphabet check (one step per symbol), the divide loop, then emit
// a new value is taken only in idle, once the previous last digit is in the output register
// the divide loop sets the rate: one 8-bit slice of the 32-bit value per cycle
// a value with an invalid alphabet ends after the check with no beats
// synchronous active-low reset restores the default radix and alphabet and idles
`default_nettype none

module signed_radix_digit_emitter import srde_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [SYM_W-1:0]     m_symbol,
    output logic                      m_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [RADIX_W-1:0]       base_length_reg;
    logic [CFG_W-1:0]         symbols_low_reg;
    logic [CFG_W-1:0]         symbols_high_reg;
    logic [VALUE_W-1:0]       work_reg, work_next;
    logic [DIGIT_W-1:0]       rem_reg, rem_next;
    logic [SLICE_CNT_W-1:0]   slice_reg, slice_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [DIGIT_W-1:0]       idx_reg, idx_next;
    logic                     neg_reg, neg_next;
    logic                     m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]         m_symbol_reg, m_symbol_next;
    logic                     m_last_reg, m_last_next;
    logic [DIGIT_W-1:0]       stack_reg [MAX_DIGITS];

    logic [TBL_W-1:0]         tbl;
    logic [SYM_W-1:0]         sym_i;
    logic                     bad;
    logic [DIGIT_W-1:0]       last_idx;
    logic [DIGIT_W-1:0]       div_rem;
    logic [SLICE_W-1:0]       div_quot;
    logic [VALUE_W-1:0]       quot_full;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     out_free;
    logic                     push;
    logic                     pop;

    assign tbl      = {symbols_high_reg, symbols_low_reg};
    assign sym_i    = symbol_at(tbl, idx_reg);
    assign last_idx = DIGIT_W'(base_length_reg - RADIX_W'(1));
    assign out_free = !m_valid_reg || m_ready;
    assign quot_full = {work_reg[VALUE_W-SLICE_W-1:0], div_quot};
    assign cnt_inc  = cnt_reg + CNT_W'(1);

    srde_div_slice u_div (
        .rem_in  (rem_reg),
        .chunk   (work_reg[VALUE_W-1 -: SLICE_W]),
        .radix   (base_length_reg),
        .rem_out (div_rem),
        .quot    (div_quot)
    );

    // alphabet check: radix in range, symbol not a sign, and no later symbol in use equal to it
    always_comb begin
        bad = (base_length_reg < RADIX_W'(2)) || (base_length_reg > RADIX_W'(MAX_RADIX))
            || (sym_i == SYM_MINUS) || (sym_i == SYM_PLUS);
        for (int j = 0; j < MAX_RADIX; j++) begin
            if ((DIGIT_W'(j) > idx_reg) && (RADIX_W'(j) < base_length_reg)
                && (symbol_at(tbl, DIGIT_W'(j)) == sym_i)) begin
                bad = 1'b1;
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        work_next     = work_reg;
        rem_next      = rem_reg;
        slice_next    = slice_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        neg_next      = neg_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_symbol_next = m_symbol_reg;
        m_last_next   = m_last_reg;
        push          = 1'b0;
        pop           = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                    neg_next   = s_value[VALUE_W-1];
                    work_next  = s_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(s_value))
                                                    : VALUE_W'(s_value);
                    idx_next   = '0;
                end
            end
            ST_CHECK: begin
                if (bad) begin
                    state_next = ST_IDLE;
                end else if (idx_reg == last_idx) begin
                    state_next = ST_DIV;
                    rem_next   = '0;
                    slice_next = '0;
                    cnt_next   = '0;
                end else begin
                    idx_next = idx_reg + DIGIT_W'(1);
                end
            end
            ST_DIV: begin
                work_next  = quot_full;
                rem_next   = div_rem;
                slice_next = slice_reg + SLICE_CNT_W'(1);
                if (slice_reg == SLICE_CNT_W'(SLICES - 1)) begin
                    push     = 1'b1;
                    cnt_next = cnt_inc;
                    rem_next = '0;
                    if ((quot_full == '0) || (cnt_inc == CNT_W'(MAX_DIGITS))) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (neg_reg) begin
                        neg_next      = 1'b0;
                        m_symbol_next = SYM_MINUS;
                        m_last_next   = 1'b0;
                    end else begin
                        pop           = 1'b1;
                        m_symbol_next = symbol_at(tbl, stack_reg[0]);
                        m_last_next   = (cnt_reg == CNT_W'(1));
                        cnt_next      = cnt_reg - CNT_W'(1);
                        if (cnt_reg == CNT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            base_length_reg  <= BASE_LENGTH_RST;
            symbols_low_reg  <= SYMBOLS_LOW_RST;
            symbols_high_reg <= SYMBOLS_HIGH_RST;
            m_valid_reg      <= 1'b0;
            neg_reg          <= 1'b0;
            cnt_reg          <= '0;
            idx_reg          <= '0;
            slice_reg        <= '0;
            rem_reg          <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            neg_reg     <= neg_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            slice_reg   <= slice_next;
            rem_reg     <= rem_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_BASE_LENGTH:  base_length_reg  <= cfg_wdata[RADIX_W-1:0];
                    CFG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_wdata;
                    CFG_SYMBOLS_HIGH: symbols_high_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        work_reg     <= work_next;
        m_symbol_reg <= m_symbol_next;
        m_last_reg   <= m_last_next;
    end

    // digit stack: newest (most significant) digit at the bottom
    always_ff @(posedge aclk) begin
        if (push) begin
            stack_reg[0] <= div_rem;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_last   = m_last_reg;

endmodule

`default_nettype wire

/* sv/srde_checker.sv */
// port-level checks for the radix digit emitter and their bind
`default_nettype none

module srde_checker import srde_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [SYM_W-1:0]     m_symbol,
    input wire logic                 m_last
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // an accepted value keeps the input closed for at least the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high right after accept");

    // the sign beat is never the final beat
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_symbol == SYM_MINUS) |-> !m_last)
        else $error("minus sign flagged last");

    // a stalled beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_symbol) && $stable(m_last))
        else $error("output beat changed while stalled");

endmodule

bind signed_radix_digit_emitter srde_checker u_srde_checker (.*);

`default_nettype wire
